// ===== design/tpm_pkg.sv =====
// Shared types, codes and sizes for the TCP port match table.
// Used by tpm_cell and tcp_port_match_table; no dependencies.
`timescale 1ns / 1ps

package tpm_pkg;

	localparam int DYN_ENTRIES = 5;
	localparam int PTR_W = (DYN_ENTRIES > 1) ? $clog2(DYN_ENTRIES) : 1;

	localparam logic [1:0] MODE_MATCH = 2'd0;
	localparam logic [1:0] MODE_ADD   = 2'd1;
	localparam logic [1:0] MODE_DEL   = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	localparam logic [1:0] DIR_IN  = 2'd0;
	localparam logic [1:0] DIR_OUT = 2'd1;

	localparam logic [1:0] STAT_NONE         = 2'd0;
	localparam logic [1:0] STAT_ADD_EMPTY    = 2'd0;
	localparam logic [1:0] STAT_ADD_REPLACED = 2'd1;
	localparam logic [1:0] STAT_ADD_PRESENT  = 2'd2;
	localparam logic [1:0] STAT_DEL_REMOVED  = 2'd0;
	localparam logic [1:0] STAT_DEL_ABSENT   = 2'd1;
	localparam logic [1:0] STAT_QRY_ABSENT   = 2'd0;
	localparam logic [1:0] STAT_QRY_FOUND    = 2'd1;
	localparam logic [1:0] STAT_INVALID      = 2'd3;

	localparam logic [1:0] REG_LOCAL_ADDR    = 2'd0;
	localparam logic [1:0] REG_STATIC_PORT_A = 2'd1;
	localparam logic [1:0] REG_STATIC_PORT_B = 2'd2;

	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [PORT_W-1:0] port_t;

	// token that walks the cell row, one cell per cycle
	typedef struct packed {
		logic  vld;
		logic  wr;
		logic  del;
		port_t key;
		logic  found;
		logic  empty_seen;
		logic  done;
		ptr_t  rp;
	} tok_t;

endpackage

// ===== design/tpm_cell.sv =====
// One dynamic port entry of the table and its stage of the token row.
// Depends on tpm_pkg.
`timescale 1ns / 1ps

module tpm_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  tpm_pkg::ptr_t idx,
	input  tpm_pkg::tok_t tok_i,
	output tpm_pkg::tok_t tok_o
);
	import tpm_pkg::*;

	port_t entry_q;
	tok_t  tok_q;
	logic  match;
	logic  empty;
	logic  wr_hit;
	tok_t  tok_nxt;

	always_comb begin
		match  = (entry_q != '0) && (entry_q == tok_i.key);
		empty  = (entry_q == '0);
		wr_hit = tok_i.wr && (tok_i.empty_seen ? (empty && !tok_i.done) : (tok_i.rp == idx));
		tok_nxt            = tok_i;
		tok_nxt.found      = tok_i.found | (match && !tok_i.wr);
		tok_nxt.empty_seen = tok_i.empty_seen | (empty && !tok_i.wr);
		tok_nxt.done       = tok_i.done | wr_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (tok_i.vld) begin
			if (wr_hit) begin
				entry_q <= tok_i.key;
			end else if (!tok_i.wr && tok_i.del && match && !tok_i.found) begin
				entry_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_o = tok_q;

endmodule

// ===== design/tcp_port_match_table.sv =====
// Top level of the TCP port match table: control, configuration and the cell row.
// Depends on tpm_pkg and tpm_cell.
`timescale 1ns / 1ps

// One item at a time. An accepted item sends a token down a row of DYN_ENTRIES
// cells, one cell per cycle, that probes the dynamic entries (and clears the
// first match on delete). Match, delete, query and add of a present or invalid
// port raise done, through the done register, once the token leaves the row;
// an add that stores the port runs a second pass to write the slot and raises
// done after it. busy is low again in the cycle done is high, so the next start
// may be taken then; no new item is taken while one is in flight. Results
// cannot be held off: done is high for a single cycle, and hit, set_mark and
// status are valid then and hold until the next result. Configuration writes
// are always ready and must only be issued while busy is low.
module tcp_port_match_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [16:0] op_port,
	input  logic        is_ipv4,
	input  logic        is_tcp,
	input  logic [1:0]  direction,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic        already_marked,
	output logic        done,
	output logic        hit,
	output logic        set_mark,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tpm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_FILL  = 2'd2;

	logic [1:0]        state_q;
	logic              launch_q;
	logic              done_q;
	ptr_t              rp_q;
	logic [ADDR_W-1:0] local_addr_q;
	port_t             static_a_q;
	port_t             static_b_q;

	logic [1:0] mode_q;
	port_t      key_q;
	logic       inv_q;
	logic       elig_q;
	logic       marked_q;
	logic       tcp_ok_q;
	logic       found0_q;
	logic       del_q;
	logic       wr_q;
	logic       empty_q;
	logic       hit_q;
	logic       set_mark_q;
	logic [1:0] status_q;

	tok_t chain [DYN_ENTRIES+1];
	tok_t tail;

	logic              accept;
	logic              cfg_wr;
	logic [ADDR_W-1:0] loc_addr;
	port_t             loc_port;
	port_t             key;
	logic              dir_ok;
	logic              inv;
	logic              static_hit;
	logic              fin_probe;
	logic              fin_fill;
	logic              need_fill;
	logic              res_fire;
	logic              res_hit;
	logic              res_mark;
	logic [1:0]        res_status;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		dir_ok     = (direction inside {DIR_IN, DIR_OUT});
		loc_addr   = (direction == DIR_OUT) ? src_addr : dst_addr;
		loc_port   = (direction == DIR_OUT) ? src_port : dst_port;
		key        = (mode == MODE_MATCH) ? loc_port : op_port[PORT_W-1:0];
		inv        = (op_port == '0) || op_port[16];
		static_hit = ((static_a_q != '0) && (static_a_q == key)) ||
		             ((static_b_q != '0) && (static_b_q == key));
	end

	// inject the token at the head of the row
	assign chain[0] = {launch_q, wr_q, del_q, key_q, found0_q, empty_q, 1'b0, rp_q};

	for (genvar g = 0; g < DYN_ENTRIES; g++) begin : g_cell
		tpm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (PTR_W'(g)),
			.tok_i  (chain[g]),
			.tok_o  (chain[g+1])
		);
	end

	assign tail = chain[DYN_ENTRIES];

	always_comb begin
		fin_probe  = (state_q == ST_PROBE) && tail.vld;
		fin_fill   = (state_q == ST_FILL) && tail.vld;
		need_fill  = fin_probe && (mode_q == MODE_ADD) && !inv_q && !tail.found;
		res_fire   = (fin_probe && !need_fill) || fin_fill;
		res_hit    = 1'b0;
		res_mark   = 1'b0;
		res_status = STAT_NONE;
		if (fin_fill) begin
			res_status = empty_q ? STAT_ADD_EMPTY : STAT_ADD_REPLACED;
		end else begin
			case (mode_q)
				MODE_MATCH: begin
					res_hit  = elig_q && (marked_q || (tcp_ok_q && tail.found));
					res_mark = elig_q && !marked_q && tcp_ok_q && tail.found;
				end
				MODE_ADD: begin
					res_status = inv_q ? STAT_INVALID : STAT_ADD_PRESENT;
				end
				MODE_DEL: begin
					res_status = inv_q ? STAT_INVALID :
					             (tail.found ? STAT_DEL_REMOVED : STAT_DEL_ABSENT);
				end
				MODE_QUERY: begin
					res_status = inv_q ? STAT_INVALID :
					             (tail.found ? STAT_QRY_FOUND : STAT_QRY_ABSENT);
				end
				default: begin
					res_status = STAT_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			launch_q     <= 1'b0;
			done_q       <= 1'b0;
			rp_q         <= '0;
			local_addr_q <= '0;
			static_a_q   <= PORT_W'(445);
			static_b_q   <= PORT_W'(20);
		end else begin
			launch_q <= accept || need_fill;
			done_q   <= res_fire;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (need_fill) begin
						state_q <= ST_FILL;
					end else if (res_fire) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FILL: begin
					if (fin_fill) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fin_fill && !empty_q) begin
				rp_q <= (rp_q == PTR_W'(DYN_ENTRIES - 1)) ? '0 : rp_q + 1'b1;
			end
			if (cfg_wr) begin
				case (cfg_index)
					REG_LOCAL_ADDR:    local_addr_q <= cfg_data;
					REG_STATIC_PORT_A: static_a_q   <= cfg_data[PORT_W-1:0];
					REG_STATIC_PORT_B: static_b_q   <= cfg_data[PORT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			key_q    <= key;
			inv_q    <= inv;
			elig_q   <= (local_addr_q != '0) && is_ipv4;
			marked_q <= already_marked;
			tcp_ok_q <= is_tcp && dir_ok && (loc_addr == local_addr_q);
			found0_q <= static_hit && ((mode == MODE_MATCH) || (mode == MODE_ADD));
			del_q    <= (mode == MODE_DEL) && !inv;
			wr_q     <= 1'b0;
			empty_q  <= 1'b0;
		end else if (need_fill) begin
			wr_q     <= 1'b1;
			del_q    <= 1'b0;
			found0_q <= 1'b0;
			empty_q  <= tail.empty_seen;
		end
		if (res_fire) begin
			hit_q      <= res_hit;
			set_mark_q <= res_mark;
			status_q   <= res_status;
		end
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign set_mark = set_mark_q;
	assign status   = status_q;

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> (state_q != ST_IDLE))
		else $error("token left the cell row while idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && launch_q))
		else $error("start transfer did not launch a token");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) != ST_IDLE))
		else $error("result strobe without an item in flight");

	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rp_q} < (PTR_W + 1)'(DYN_ENTRIES))
		else $error("replace pointer out of range");

	a_mark_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && set_mark) |-> (hit && (status == STAT_NONE)))
		else $error("mark request without a hit");

endmodule
